// ===== src/npt_pkg.sv =====
// Package for the nearest feature point classifier.
// Holds the channel words, register indexes, FSM states and the control structs.
// No dependencies.
package npt_pkg;

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } op_t;

    localparam logic [1:0] REG_POINT_COUNT = 2'd0;
    localparam logic [1:0] REG_WHITE_LEVEL = 2'd1;
    localparam logic [1:0] REG_BLACK_LEVEL = 2'd2;

    localparam logic [8:0]  POINT_COUNT_RESET = 9'd100;
    localparam logic [15:0] WHITE_LEVEL_RESET = 16'hFFFF;
    localparam logic [15:0] BLACK_LEVEL_RESET = 16'h0000;

    localparam int          OUT_DIST_W = 33;
    localparam logic [32:0] OUT_DIST_MAX = 33'h1_FFFF_FFFF;

    typedef struct packed {
        logic        operation;
        logic [7:0]  point_slot;
        logic [15:0] point_x;
        logic [15:0] point_y;
        logic        point_dark;
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
    } req_t;

    typedef struct packed {
        logic [7:0]  nearest_index;
        logic [32:0] nearest_distance;
        logic        is_dark;
        logic [15:0] level;
    } res_t;

    typedef struct packed {
        logic [1:0]  reg_index;
        logic [15:0] value;
    } cfg_t;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic        dark;
    } point_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    typedef struct packed {
        logic load;
        logic start;
        logic rd_en;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic scan_empty;
        logic scan_last;
        logic pipe_busy;
        logic out_full;
    } status_t;

endpackage

// ===== src/npt_stream_if.sv =====
// Valid/ready channel interface used for the request, result and register ports.
// The word type is a parameter; the word types live in npt_pkg.
interface npt_stream_if #(
    parameter type word_t = logic
);
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/npt_ctrl.sv =====
// Sequencing FSM of the nearest feature point classifier.
// Depends on npt_pkg for the state, command and status types.
module npt_ctrl
    import npt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    in_op,
    output logic    in_ready,
    output cmd_t    cmd,
    input  status_t status
);

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_op == OP_QUERY)
                    begin
                        cmd.start  = 1'b1;
                        state_next = status.scan_empty ? ST_FINISH : ST_SCAN;
                    end
                    else
                    begin
                        cmd.load = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (status.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!status.out_full)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/npt_datapath.sv =====
// Point store, distance pipeline, running minimum, registers and result register.
// Depends on npt_pkg; driven by npt_ctrl through cmd_t and status_t.
module npt_datapath
    import npt_pkg::*;
#(
    parameter int MAX_POINTS    = 256,
    parameter int FRACTION_BITS = 4
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  cmd_t    cmd,
    output status_t status,
    input  req_t    req,
    input  logic    cfg_valid,
    input  cfg_t    cfg_word,
    output logic    res_valid,
    input  logic    res_ready,
    output res_t    res_word
);

    localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int LIM_W = (CNT_W > 9) ? CNT_W : 9;
    localparam int CW    = ((12 + FRACTION_BITS) > 16) ? (12 + FRACTION_BITS) : 16;
    localparam int DW    = 2 * CW + 1;
    localparam logic [DW-1:0] SAT = DW'(OUT_DIST_MAX);

    logic [8:0]  count_reg;
    logic [15:0] white_reg;
    logic [15:0] black_reg;

    point_t mem [MAX_POINTS];
    point_t mem_q_reg;

    logic [CNT_W-1:0] rd_addr_reg;
    logic [CNT_W-1:0] addr_inc;
    logic [CNT_W-1:0] scan_len;
    logic [LIM_W-1:0] cnt_ext;
    logic [LIM_W-1:0] lim;
    logic [LIM_W-1:0] n_full;
    logic [12:0]      slot_ext;
    logic             slot_ok;

    logic [CW-1:0] px_reg;
    logic [CW-1:0] py_reg;
    logic [CW-1:0] px_ext;
    logic [CW-1:0] py_ext;

    logic          s0_v_reg;
    logic [AW-1:0] s0_idx_reg;
    logic          s1_v_reg;
    logic [AW-1:0] s1_idx_reg;
    logic          s1_dark_reg;
    logic [CW-1:0] dx_reg;
    logic [CW-1:0] dy_reg;
    logic          s2_v_reg;
    logic [AW-1:0] s2_idx_reg;
    logic          s2_dark_reg;
    logic [2*CW-1:0] sx_reg;
    logic [2*CW-1:0] sy_reg;

    logic [CW-1:0] qx;
    logic [CW-1:0] qy;
    logic [DW-1:0] dist_sum;

    logic          found_reg;
    logic [DW-1:0] best_dist_reg;
    logic [AW-1:0] best_idx_reg;
    logic          best_dark_reg;

    logic [AW+7:0] idx_ext;
    logic          out_valid_reg;
    res_t          out_word_reg;

    assign cnt_ext  = LIM_W'(count_reg);
    assign lim      = LIM_W'(MAX_POINTS);
    assign n_full   = (cnt_ext > lim) ? lim : cnt_ext;
    assign scan_len = n_full[CNT_W-1:0];
    assign addr_inc = rd_addr_reg + CNT_W'(1);
    assign slot_ext = 13'(req.point_slot);
    assign slot_ok  = slot_ext < 13'(MAX_POINTS);

    assign px_ext = CW'(req.pixel_x);
    assign py_ext = CW'(req.pixel_y);

    assign qx       = CW'(mem_q_reg.x);
    assign qy       = CW'(mem_q_reg.y);
    assign dist_sum = DW'(sx_reg) + DW'(sy_reg);
    assign idx_ext  = (AW + 8)'(best_idx_reg);

    assign status.scan_empty = (scan_len == '0);
    assign status.scan_last  = (addr_inc == scan_len);
    assign status.pipe_busy  = s0_v_reg | s1_v_reg | s2_v_reg;
    assign status.out_full   = out_valid_reg & ~res_ready;

    assign res_valid = out_valid_reg;
    assign res_word  = out_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= POINT_COUNT_RESET;
            white_reg <= WHITE_LEVEL_RESET;
            black_reg <= BLACK_LEVEL_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_word.reg_index)
                REG_POINT_COUNT: count_reg <= cfg_word.value[8:0];
                REG_WHITE_LEVEL: white_reg <= cfg_word.value;
                REG_BLACK_LEVEL: black_reg <= cfg_word.value;
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load && slot_ok)
        begin
            mem[slot_ext[AW-1:0]] <= '{x: req.point_x, y: req.point_y, dark: req.point_dark};
        end
        if (cmd.rd_en)
        begin
            mem_q_reg <= mem[rd_addr_reg[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_v_reg      <= 1'b0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s0_v_reg <= cmd.rd_en;
            s1_v_reg <= s0_v_reg;
            s2_v_reg <= s1_v_reg;
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            rd_addr_reg   <= '0;
            px_reg        <= px_ext << FRACTION_BITS;
            py_reg        <= py_ext << FRACTION_BITS;
            found_reg     <= 1'b0;
            best_dist_reg <= '0;
            best_idx_reg  <= '0;
            best_dark_reg <= 1'b0;
        end
        else
        begin
            if (cmd.rd_en)
            begin
                rd_addr_reg <= addr_inc;
            end
            if (s2_v_reg && (!found_reg || (dist_sum < best_dist_reg)))
            begin
                found_reg     <= 1'b1;
                best_dist_reg <= dist_sum;
                best_idx_reg  <= s2_idx_reg;
                best_dark_reg <= s2_dark_reg;
            end
        end

        s0_idx_reg  <= rd_addr_reg[AW-1:0];
        s1_idx_reg  <= s0_idx_reg;
        s1_dark_reg <= mem_q_reg.dark;
        dx_reg      <= (qx >= px_reg) ? (qx - px_reg) : (px_reg - qx);
        dy_reg      <= (qy >= py_reg) ? (qy - py_reg) : (py_reg - qy);
        s2_idx_reg  <= s1_idx_reg;
        s2_dark_reg <= s1_dark_reg;
        sx_reg      <= dx_reg * dx_reg;
        sy_reg      <= dy_reg * dy_reg;

        if (cmd.finish)
        begin
            out_word_reg.nearest_index    <= idx_ext[7:0];
            out_word_reg.nearest_distance <= (best_dist_reg > SAT) ? OUT_DIST_MAX
                                                                   : best_dist_reg[OUT_DIST_W-1:0];
            out_word_reg.is_dark          <= best_dark_reg;
            out_word_reg.level            <= best_dark_reg ? black_reg : white_reg;
        end
    end

endmodule

// ===== src/nearest_point_two_class_stencil.sv =====
// Top level of the nearest feature point classifier.
// Depends on npt_pkg, npt_stream_if, npt_ctrl and npt_datapath.
//
// Channels: request carries one word per load or query, result carries one word
// per query, and cfg writes the point count, white level and black level.
// A load writes one store entry and leaves the controller idle; loads to slots
// beyond the store are dropped. A query scans entries 0 to n-1, where n is the
// point count limited to MAX_POINTS, one entry per cycle through a four-stage
// read, difference, square and compare pipeline. In the finish state, once the
// pipeline has drained, the result word is loaded into the output register; when
// n is 0 the query goes straight to the finish state. No new request is taken
// until the query has finished and the controller is back in idle.
// Register writes are accepted in every cycle.
// The result sits in an output register, so request stays open while a result
// waits; a query that finishes while the previous result is still stalled holds
// until the receiver takes it. Reset empties the pipeline and the output
// register and restores the register defaults; the point store has no reset and
// every entry must be loaded before a query scans it.
module nearest_point_two_class_stencil
    import npt_pkg::*;
#(
    parameter int MAX_POINTS    = 256,
    parameter int FRACTION_BITS = 4
)
(
    input logic          clk,
    input logic          rst_n,
    npt_stream_if.sink   request,
    npt_stream_if.source result,
    npt_stream_if.sink   cfg
);

    cmd_t    cmd;
    status_t status;
    req_t    req_word;
    res_t    res_word;
    cfg_t    cfg_word;
    logic    req_ready;
    logic    res_valid;

    assign req_word      = request.data;
    assign cfg_word      = cfg.data;
    assign request.ready = req_ready;
    assign cfg.ready     = 1'b1;
    assign result.valid  = res_valid;
    assign result.data   = res_word;

    npt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_op    (req_word.operation),
        .in_ready (req_ready),
        .cmd      (cmd),
        .status   (status)
    );

    npt_datapath #(
        .MAX_POINTS    (MAX_POINTS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .req       (req_word),
        .cfg_valid (cfg.valid),
        .cfg_word  (cfg_word),
        .res_valid (res_valid),
        .res_ready (result.ready),
        .res_word  (res_word)
    );

endmodule

// ===== src/npt_checker.sv =====
// Port-level assertions for the nearest feature point classifier.
// Depends on npt_pkg; bound to nearest_point_two_class_stencil below.
module npt_checker
    import npt_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic req_valid,
    input logic req_ready,
    input req_t req_word,
    input logic res_valid,
    input logic res_ready,
    input res_t res_word
);

    logic query_acc;
    logic load_acc;

    assign query_acc = req_valid && req_ready && (req_word.operation == OP_QUERY);
    assign load_acc  = req_valid && req_ready && (req_word.operation == OP_LOAD);

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result word dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_word))
        else $error("result word changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        query_acc |=> !req_ready)
        else $error("request open while a query is in progress");

    assert property (@(posedge clk) disable iff (!rst_n)
        load_acc && !res_valid |=> !res_valid)
        else $error("load produced a result word");

endmodule

bind nearest_point_two_class_stencil npt_checker u_npt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .req_word  (request.data),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .res_word  (result.data)
);

// ===== verif/npt_classify_check.sv =====
`timescale 1ns / 1ps
// Checker for the nearest feature point classifier: mirrors the point store and the
// registers, predicts each pixel classification and compares it with the result word.
// Depends on npt_pkg.
module npt_classify_check
    import npt_pkg::*;
#(
    parameter int MAX_POINTS    = 256,
    parameter int FRACTION_BITS = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_ready,
    input  req_t req_data,
    input  logic res_valid,
    input  logic res_ready,
    input  res_t res_data,
    input  logic cfg_valid,
    input  logic cfg_ready,
    input  cfg_t cfg_data,
    output int   errors,
    output int   pending,
    output int   loads_seen,
    output int   queries_checked
);

    point_t      points [MAX_POINTS];
    logic [8:0]  count_reg;
    logic [15:0] white_reg;
    logic [15:0] black_reg;
    res_t        classifications_due [$];

    function automatic res_t classify_pixel(input logic [11:0] px, input logic [11:0] py);
        longint unsigned fx;
        longint unsigned fy;
        longint unsigned dx;
        longint unsigned dy;
        longint unsigned sq_dist;
        longint unsigned best;
        int              n;
        int              best_i;
        int              i;
        bit              found;
        res_t            r;
        fx = longint'(px) << FRACTION_BITS;
        fy = longint'(py) << FRACTION_BITS;
        n = (count_reg > MAX_POINTS) ? MAX_POINTS : int'(count_reg);
        best = 0;
        best_i = 0;
        found = 1'b0;
        for (i = 0; i < n; i++)
        begin
            dx = (points[i].x >= fx) ? points[i].x - fx : fx - points[i].x;
            dy = (points[i].y >= fy) ? points[i].y - fy : fy - points[i].y;
            sq_dist = dx * dx + dy * dy;
            if (!found || sq_dist < best)
            begin
                found = 1'b1;
                best = sq_dist;
                best_i = i;
            end
        end
        r.nearest_index = 8'(best_i);
        r.nearest_distance = (best > OUT_DIST_MAX) ? OUT_DIST_MAX : 33'(best);
        r.is_dark = found ? points[best_i].dark : 1'b0;
        r.level = r.is_dark ? black_reg : white_reg;
        return r;
    endfunction

    task automatic flag_field(input string name, input logic [32:0] want,
                              input logic [32:0] got);
        if (got !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        res_t want;
        if (!rst_n)
        begin
            count_reg = POINT_COUNT_RESET;
            white_reg = WHITE_LEVEL_RESET;
            black_reg = BLACK_LEVEL_RESET;
            foreach (points[i])
                points[i] = '0;
            classifications_due.delete();
            errors = 0;
            pending = 0;
            loads_seen = 0;
            queries_checked = 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (classifications_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: result word with no query waiting, expected none, got %h",
                             $time, res_data);
                end
                else
                begin
                    want = classifications_due.pop_front();
                    flag_field("nearest_index", want.nearest_index, res_data.nearest_index);
                    flag_field("nearest_distance", want.nearest_distance,
                               res_data.nearest_distance);
                    flag_field("is_dark", want.is_dark, res_data.is_dark);
                    flag_field("level", want.level, res_data.level);
                    queries_checked++;
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_data.reg_index)
                    REG_POINT_COUNT: count_reg = cfg_data.value[8:0];
                    REG_WHITE_LEVEL: white_reg = cfg_data.value;
                    REG_BLACK_LEVEL: black_reg = cfg_data.value;
                    default: ;
                endcase
            end
            if (req_valid && req_ready)
            begin
                if (req_data.operation == OP_LOAD)
                begin
                    if (req_data.point_slot < MAX_POINTS)
                        points[req_data.point_slot] = '{req_data.point_x, req_data.point_y,
                                                        req_data.point_dark};
                    loads_seen++;
                end
                else
                    classifications_due.push_back(classify_pixel(req_data.pixel_x,
                                                                 req_data.pixel_y));
            end
            pending = classifications_due.size();
        end
    end

endmodule

// ===== verif/tb_nearest_point_two_class_stencil.sv =====
`timescale 1ns / 1ps
// Testbench top for the nearest feature point classifier: drives loads, pixel queries
// and register writes under several idle patterns and gives the verdict.
// Depends on npt_pkg, npt_stream_if, the block and npt_classify_check.
module tb_nearest_point_two_class_stencil;
    import npt_pkg::*;

    localparam int MAX_POINTS    = 256;
    localparam int FRACTION_BITS = 4;
    localparam int QUIET_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 16;

    logic        clk;
    logic        rst_n;
    int          send_gap_pct = 0;
    int          stall_pct = 0;
    int          current_count = int'(POINT_COUNT_RESET);
    int          writes_done = 0;
    int          errors;
    int          pending;
    int          loads_seen;
    int          queries_checked;
    logic [11:0] hot_px = 12'd2048;
    logic [11:0] hot_py = 12'd1024;

    npt_stream_if #(.word_t(req_t)) req_if ();
    npt_stream_if #(.word_t(res_t)) res_if ();
    npt_stream_if #(.word_t(cfg_t)) cfg_if ();

    nearest_point_two_class_stencil #(
        .MAX_POINTS   (MAX_POINTS),
        .FRACTION_BITS(FRACTION_BITS)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .request(req_if),
        .result (res_if),
        .cfg    (cfg_if)
    );

    npt_classify_check #(
        .MAX_POINTS   (MAX_POINTS),
        .FRACTION_BITS(FRACTION_BITS)
    ) classify_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_if.valid),
        .req_ready      (req_if.ready),
        .req_data       (req_if.data),
        .res_valid      (res_if.valid),
        .res_ready      (res_if.ready),
        .res_data       (res_if.data),
        .cfg_valid      (cfg_if.valid),
        .cfg_ready      (cfg_if.ready),
        .cfg_data       (cfg_if.data),
        .errors         (errors),
        .pending        (pending),
        .loads_seen     (loads_seen),
        .queries_checked(queries_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("Watchdog: no word moved for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, pending);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic logic [15:0] coord(input int top);
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 1) ? 16'(top) : 16'd0;
        return 16'($urandom_range(0, top));
    endfunction

    function automatic logic [15:0] near_coord(input logic [11:0] pixel);
        int c;
        c = (int'(pixel) << FRACTION_BITS) + int'($urandom_range(0, 6)) - 3;
        if (c < 0)
            c = 0;
        else if (c > 65535)
            c = 65535;
        return c[15:0];
    endfunction

    function automatic req_t random_word();
        req_t w;
        w.operation = $urandom_range(0, 1) ? OP_QUERY : OP_LOAD;
        w.point_slot = 8'($urandom_range(0, 255));
        w.point_x = coord(65535);
        w.point_y = coord(65535);
        w.point_dark = 1'($urandom_range(0, 1));
        w.pixel_x = 12'(coord(4095));
        w.pixel_y = 12'(coord(4095));
        return w;
    endfunction

    task automatic push_request(input req_t w);
        while ($urandom_range(0, 99) < send_gap_pct)
        begin
            req_if.valid <= 1'b0;
            @(posedge clk);
        end
        req_if.valid <= 1'b1;
        req_if.data <= w;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
    endtask

    task automatic load_point(input logic [7:0] slot, input logic [15:0] x,
                              input logic [15:0] y, input logic dark);
        req_t w;
        w = random_word();
        w.operation = OP_LOAD;
        w.point_slot = slot;
        w.point_x = x;
        w.point_y = y;
        w.point_dark = dark;
        push_request(w);
    endtask

    task automatic query_pixel(input logic [11:0] px, input logic [11:0] py);
        req_t w;
        w = random_word();
        w.operation = OP_QUERY;
        w.pixel_x = px;
        w.pixel_y = py;
        push_request(w);
    endtask

    task automatic settle();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.data <= '{reg_index: idx, value: data};
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
        @(posedge clk);
        if (idx == REG_POINT_COUNT)
            current_count = int'(data[8:0]);
        writes_done++;
    endtask

    task automatic configure(input int count, input logic [15:0] white,
                             input logic [15:0] black);
        settle();
        write_reg(REG_POINT_COUNT, 16'(count));
        write_reg(REG_WHITE_LEVEL, white);
        write_reg(REG_BLACK_LEVEL, black);
    endtask

    function automatic logic [15:0] pick_level();
        case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic int pick_count();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 1;
            2: return MAX_POINTS;
            3: return $urandom_range(41, 120);
            default: return $urandom_range(2, 40);
        endcase
    endfunction

    task automatic random_run(input int items);
        req_t w;
        int   i;
        int   span;
        for (i = 0; i < items; i++)
        begin
            w = random_word();
            if ($urandom_range(0, 99) < 45)
            begin
                w.operation = OP_LOAD;
                span = (current_count > MAX_POINTS) ? MAX_POINTS : current_count;
                if (span > 0 && $urandom_range(0, 1))
                    w.point_slot = 8'($urandom_range(0, span - 1));
                if ($urandom_range(0, 3) == 0)
                begin
                    w.point_x = near_coord(hot_px);
                    w.point_y = near_coord(hot_py);
                end
            end
            else
            begin
                w.operation = OP_QUERY;
                if ($urandom_range(0, 2) == 0)
                begin
                    w.pixel_x = hot_px;
                    w.pixel_y = hot_py;
                end
                else if ($urandom_range(0, 7) == 0)
                begin
                    hot_px = w.pixel_x;
                    hot_py = w.pixel_y;
                end
            end
            push_request(w);
        end
    endtask

    initial
    begin
        int slot;
        int mode;
        int part;
        rst_n <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.data <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.data <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Every store entry is loaded before any query, so no scan reads an unwritten entry.
        for (slot = 0; slot < MAX_POINTS; slot++)
            load_point(8'(slot), coord(65535), coord(65535), 1'($urandom_range(0, 1)));

        // Reset register values, coordinate extremes and an exact tie at the origin.
        load_point(8'd0, 16'h0000, 16'h0000, 1'b1);
        load_point(8'd1, 16'hFFFF, 16'hFFFF, 1'b0);
        load_point(8'd2, 16'h0000, 16'h0000, 1'b0);
        query_pixel(12'd0, 12'd0);
        query_pixel(12'd4095, 12'd4095);
        query_pixel(12'd4095, 12'd0);
        query_pixel(12'd0, 12'd4095);

        configure(2, 16'h1234, 16'hABCD);
        query_pixel(12'd4095, 12'd4095);
        query_pixel(12'd0, 12'd0);
        load_point(8'd1, 16'h0640, 16'h0C80, 1'b1);
        load_point(8'd0, 16'h0640, 16'h0C80, 1'b0);
        query_pixel(12'd100, 12'd200);

        configure(0, 16'h0000, 16'hFFFF);
        query_pixel(12'd123, 12'd456);
        configure(1, 16'hFFFF, 16'h0000);
        query_pixel(12'd5, 12'd5);
        configure(MAX_POINTS, 16'h0000, 16'hFFFF);
        query_pixel(12'd2048, 12'd2048);
        configure(300, 16'h8001, 16'h7FFE);
        query_pixel(12'd4095, 12'd4095);
        configure(511, 16'hFFFF, 16'hFFFF);
        query_pixel(12'd0, 12'd0);

        for (mode = 0; mode < 4; mode++)
        begin
            for (part = 0; part < 3; part++)
            begin
                configure(pick_count(), pick_level(), pick_level());
                case (mode)
                    0: begin send_gap_pct = 0;  stall_pct = 0;  end
                    1: begin send_gap_pct = 58; stall_pct = 0;  end
                    2: begin send_gap_pct = 0;  stall_pct = 58; end
                    default: begin send_gap_pct = 6; stall_pct = 6; end
                endcase
                random_run(128);
            end
        end

        settle();
        repeat (MAX_POINTS + SETTLE_CYCLES) @(posedge clk);
        $display("Covered %0d point loads and %0d checked pixel queries over %0d register writes,",
                 loads_seen, queries_checked, writes_done);
        $display("with free-running, sender-gap, receiver-stall and light mixed idle patterns.");
        if (errors == 0 && pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
